### rtl/core/tensor_trilinear_discriminant_unit_assert.svh
// Assertion macros used by the tensor discriminant unit RTL
`ifndef TENSOR_TRILINEAR_DISCRIMINANT_UNIT_ASSERT_SVH
`define TENSOR_TRILINEAR_DISCRIMINANT_UNIT_ASSERT_SVH

// Checked property, switched off while reset is high
`define TTDU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ttdu assertion failed");

// Checked property, also active during reset
`define TTDU_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("ttdu assertion failed");

`endif

### rtl/core/ttd_pkg.sv
// Types, constants and micro-op table of the tensor discriminant unit
package ttd_pkg;

   localparam int VAL_W   = 20;
   localparam int COORD_W = 18;
   localparam int VTX_W   = 3;
   localparam int COMP_W  = 4;
   localparam int AUX_W   = 48;
   localparam int ADDR_W  = 7;
   localparam int UOP_W   = 6;
   localparam int NUM_UOPS = 34;

   typedef logic signed [63:0] word_type;

   localparam word_type WORD_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam word_type WORD_MIN  = 64'sh8000_0000_0000_0000;
   localparam word_type VAL_MAX_W = 64'sd524287;
   localparam logic [AUX_W-1:0] AUX_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [AUX_W-1:0] AUX_MIN = 48'h8000_0000_0000;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;
   localparam logic [COMP_W-1:0] LAST_COMP = 4'd8;
   localparam logic [VTX_W-1:0]  LAST_VTX  = 3'd7;
   localparam logic [5:0] DIV_K = 6'd27;

   // corner sign bits, bit k set where the coordinate factor is 1 + x
   localparam logic [7:0] CORNER_X_POS = 8'b0110_0110;
   localparam logic [7:0] CORNER_Y_POS = 8'b1100_1100;
   localparam logic [7:0] CORNER_Z_POS = 8'b1111_0000;
   // reset tensors: off-diagonal elements that are negative at corner k
   localparam logic [7:0] NEG_01 = 8'b1010_1010;
   localparam logic [7:0] NEG_02 = 8'b1001_0110;
   localparam logic [7:0] NEG_12 = 8'b0011_1100;

   typedef enum logic [4:0] {
      OPD_T0, OPD_T1, OPD_T2, OPD_T3, OPD_T4, OPD_T5, OPD_T6, OPD_T7, OPD_T8,
      OPD_P, OPD_Q, OPD_R, OPD_P2, OPD_Q2, OPD_P3, OPD_PQ, OPD_S1, OPD_S2,
      OPD_D, OPD_N, OPD_ONE, OPD_K2, OPD_K4, OPD_K9, OPD_K18, OPD_K27
   } operand_type;

   typedef enum logic [1:0] {ACC_SET, ACC_ADD, ACC_SUB} acc_op_type;

   typedef struct packed {
      operand_type src_a;
      operand_type src_b;
      operand_type dst;
      acc_op_type  acc;
   } uop_type;

   typedef enum logic [1:0] {MUL_RAW, MUL_FRAC, MUL_WEIGHT} mul_mode_type;

   typedef struct packed {
      logic         start;
      mul_mode_type mode;
   } mul_req_type;

   typedef struct packed {
      logic done;
      logic ovf;
   } mul_rsp_type;

   // invariant and discriminant program: dst = dst (op) a*b
   function automatic uop_type uop_rom(input logic [UOP_W-1:0] idx);
      uop_type u;
      case (idx)
         6'd0:  u = '{OPD_T0, OPD_T4, OPD_Q, ACC_SET};
         6'd1:  u = '{OPD_T1, OPD_T3, OPD_Q, ACC_SUB};
         6'd2:  u = '{OPD_T4, OPD_T8, OPD_S1, ACC_SET};
         6'd3:  u = '{OPD_T5, OPD_T7, OPD_S1, ACC_SUB};
         6'd4:  u = '{OPD_S1, OPD_ONE, OPD_Q, ACC_ADD};
         6'd5:  u = '{OPD_T8, OPD_T0, OPD_S2, ACC_SET};
         6'd6:  u = '{OPD_T6, OPD_T2, OPD_S2, ACC_SUB};
         6'd7:  u = '{OPD_S2, OPD_ONE, OPD_Q, ACC_ADD};
         6'd8:  u = '{OPD_T0, OPD_S1, OPD_R, ACC_SET};
         6'd9:  u = '{OPD_T3, OPD_T8, OPD_S2, ACC_SET};
         6'd10: u = '{OPD_T5, OPD_T6, OPD_S2, ACC_SUB};
         6'd11: u = '{OPD_T1, OPD_S2, OPD_R, ACC_SUB};
         6'd12: u = '{OPD_T3, OPD_T7, OPD_S2, ACC_SET};
         6'd13: u = '{OPD_T4, OPD_T6, OPD_S2, ACC_SUB};
         6'd14: u = '{OPD_T2, OPD_S2, OPD_R, ACC_ADD};
         6'd15: u = '{OPD_T0, OPD_ONE, OPD_P, ACC_SET};
         6'd16: u = '{OPD_T4, OPD_ONE, OPD_P, ACC_ADD};
         6'd17: u = '{OPD_T8, OPD_ONE, OPD_P, ACC_ADD};
         6'd18: u = '{OPD_P, OPD_P, OPD_P2, ACC_SET};
         6'd19: u = '{OPD_Q, OPD_Q, OPD_Q2, ACC_SET};
         6'd20: u = '{OPD_P2, OPD_P, OPD_P3, ACC_SET};
         6'd21: u = '{OPD_P, OPD_Q, OPD_PQ, ACC_SET};
         6'd22: u = '{OPD_Q2, OPD_P2, OPD_D, ACC_SET};
         6'd23: u = '{OPD_R, OPD_P3, OPD_S1, ACC_SET};
         6'd24: u = '{OPD_S1, OPD_K4, OPD_D, ACC_SUB};
         6'd25: u = '{OPD_Q2, OPD_Q, OPD_S1, ACC_SET};
         6'd26: u = '{OPD_S1, OPD_K4, OPD_D, ACC_SUB};
         6'd27: u = '{OPD_PQ, OPD_R, OPD_S1, ACC_SET};
         6'd28: u = '{OPD_S1, OPD_K18, OPD_D, ACC_ADD};
         6'd29: u = '{OPD_R, OPD_R, OPD_S1, ACC_SET};
         6'd30: u = '{OPD_S1, OPD_K27, OPD_D, ACC_SUB};
         6'd31: u = '{OPD_PQ, OPD_K9, OPD_N, ACC_SET};
         6'd32: u = '{OPD_P3, OPD_K2, OPD_N, ACC_SUB};
         6'd33: u = '{OPD_R, OPD_K27, OPD_N, ACC_SUB};
         default: u = '{OPD_ONE, OPD_ONE, OPD_S1, ACC_SET};
      endcase
      return u;
   endfunction

   // saturating add or subtract; top bit flags a clamp
   function automatic logic [64:0] sat_arith(input word_type a, input word_type b,
                                             input logic sub);
      logic signed [64:0] s;
      if (sub) s = $signed({a[63], a}) - $signed({b[63], b});
      else     s = $signed({a[63], a}) + $signed({b[63], b});
      if (s[64] != s[63]) return {1'b1, (s[64] ? WORD_MIN : WORD_MAX)};
      return {1'b0, s[63:0]};
   endfunction

endpackage

### rtl/core/ttd_if.sv
// Request and response channel interfaces of the tensor discriminant unit
interface ttd_req_if;
   import ttd_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [VTX_W-1:0]           vertex;
   logic [COMP_W-1:0]          component;
   logic signed [VAL_W-1:0]    value;
   logic signed [COORD_W-1:0]  coord_x;
   logic signed [COORD_W-1:0]  coord_y;
   logic signed [COORD_W-1:0]  coord_z;

   modport source(output valid, op, vertex, component, value, coord_x, coord_y, coord_z,
                  input ready);
   modport sink(input valid, op, vertex, component, value, coord_x, coord_y, coord_z,
                output ready);
endinterface

interface ttd_rsp_if;
   import ttd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [63:0]       disc_cubic;
   logic signed [AUX_W-1:0]  disc_aux;
   logic                     saturated;

   modport source(output valid, disc_cubic, disc_aux, saturated, input ready);
   modport sink(input valid, disc_cubic, disc_aux, saturated, output ready);
endinterface

### rtl/core/ttd_mul.sv
// Shared 64x64 signed multiplier: four 32x32 partial products, then scale and clamp
module ttd_mul #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ttd_pkg::mul_req_type mul_req,
   input  ttd_pkg::word_type    opa,
   input  ttd_pkg::word_type    opb,
   output ttd_pkg::word_type    res,
   output ttd_pkg::mul_rsp_type mul_rsp
);
   import ttd_pkg::*;

   localparam int SH_W = $clog2(FRAC_BITS + 4);

   typedef enum logic [1:0] {MS_IDLE, MS_PART, MS_SIGN, MS_SCALE} mstate_type;

   mstate_type          mstate_ff;
   mul_mode_type        mode_ff;
   logic                neg_ff;
   logic [63:0]         mag_a_ff;
   logic [63:0]         mag_b_ff;
   logic [1:0]          part_ff;
   logic [127:0]        acc_ff;
   logic signed [127:0] prod_ff;
   word_type            res_ff;
   logic                done_ff;
   logic                ovf_ff;

   logic [31:0]         half_a;
   logic [31:0]         half_b;
   logic [63:0]         pp;
   logic [127:0]        pp_shift;
   logic [SH_W-1:0]     shamt;
   logic signed [127:0] scaled;
   logic                fits;

   // partial product of the selected halves, placed at its weight
   always_comb begin
      half_a = part_ff[0] ? mag_a_ff[63:32] : mag_a_ff[31:0];
      half_b = part_ff[1] ? mag_b_ff[63:32] : mag_b_ff[31:0];
      pp     = half_a * half_b;
      case ({part_ff[1], part_ff[0]})
         2'b00:   pp_shift = {64'b0, pp};
         2'b11:   pp_shift = {pp, 64'b0};
         default: pp_shift = {32'b0, pp, 32'b0};
      endcase
   end

   // floor scaling and range check
   always_comb begin
      case (mode_ff)
         MUL_FRAC:   shamt = SH_W'(FRAC_BITS);
         MUL_WEIGHT: shamt = SH_W'(FRAC_BITS + 3);
         default:    shamt = '0;
      endcase
      scaled = prod_ff >>> shamt;
      fits   = (&scaled[127:63]) | ~(|scaled[127:63]);
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         mstate_ff <= MS_IDLE;
         done_ff   <= 1'b0;
         part_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (mstate_ff)
            MS_IDLE: begin
               if (mul_req.start) begin
                  mag_a_ff  <= opa[63] ? 64'(-opa) : 64'(opa);
                  mag_b_ff  <= opb[63] ? 64'(-opb) : 64'(opb);
                  neg_ff    <= opa[63] ^ opb[63];
                  mode_ff   <= mul_req.mode;
                  acc_ff    <= '0;
                  part_ff   <= '0;
                  mstate_ff <= MS_PART;
               end
            end
            MS_PART: begin
               acc_ff  <= acc_ff + pp_shift;
               part_ff <= part_ff + 2'd1;
               if (part_ff == 2'd3) mstate_ff <= MS_SIGN;
            end
            MS_SIGN: begin
               prod_ff   <= neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
               mstate_ff <= MS_SCALE;
            end
            MS_SCALE: begin
               if (fits)            res_ff <= scaled[63:0];
               else if (scaled[127]) res_ff <= WORD_MIN;
               else                 res_ff <= WORD_MAX;
               ovf_ff    <= ~fits;
               done_ff   <= 1'b1;
               mstate_ff <= MS_IDLE;
            end
            default: mstate_ff <= MS_IDLE;
         endcase
      end
   end

   assign res          = res_ff;
   assign mul_rsp.done = done_ff;
   assign mul_rsp.ovf  = ovf_ff;

endmodule

### rtl/core/tensor_trilinear_discriminant_unit.sv
// Tensor discriminant unit: trilinear tensor interpolation and cubic discriminant
//
// Channels: req_ch carries items (op 0 writes one component of a corner tensor, op 1
// evaluates at a point); rsp_ch returns one item per evaluate and none per write.
// Both use valid/ready, an item moving on a clock edge where both are high.
// After reset the corner table is loaded with the default tensors, one entry per
// cycle, all 72 entries, while req_ch.ready stays low.
// A write is done in the idle state, which stays ready for the next item. In an
// evaluate every multiplication goes through one shared multiplier (16 weight
// products, 72 table accumulations, 34 invariant and discriminant steps), the table
// is read one entry per product from its single port, and the final division by 27
// takes one 8-bit quotient digit per cycle for the 64-bit quotient.
// One evaluate is in work at a time. The result sits in an output register; the next
// item is accepted while it waits, and a further result waits until rsp_ch.ready
// has taken the one before.
`include "tensor_trilinear_discriminant_unit_assert.svh"

module tensor_trilinear_discriminant_unit #(
   parameter int FRAC_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   ttd_req_if.sink     req_ch,
   ttd_rsp_if.source   rsp_ch
);
   import ttd_pkg::*;

   localparam int MEM_DEPTH = 72;
   localparam word_type ONE_W = 64'sd1 <<< FRAC_BITS;
   localparam word_type K2_W  = 64'sd2 <<< FRAC_BITS;
   localparam word_type K4_W  = 64'sd4 <<< FRAC_BITS;
   localparam word_type K9_W  = 64'sd9 <<< FRAC_BITS;
   localparam word_type K18_W = 64'sd18 <<< FRAC_BITS;
   localparam word_type K27_W = 64'sd27 <<< FRAC_BITS;
   localparam word_type TH1_RAW  = (ONE_W + 64'sd1) / 64'sd3;
   localparam word_type TH4_RAW  = (64'sd4 * ONE_W + 64'sd1) / 64'sd3;
   localparam word_type TH7_RAW  = (64'sd7 * ONE_W + 64'sd1) / 64'sd3;
   localparam word_type TH10_RAW = (64'sd10 * ONE_W + 64'sd1) / 64'sd3;
   localparam logic signed [VAL_W-1:0] TH1  =
      VAL_W'(TH1_RAW > VAL_MAX_W ? VAL_MAX_W : TH1_RAW);
   localparam logic signed [VAL_W-1:0] TH4  =
      VAL_W'(TH4_RAW > VAL_MAX_W ? VAL_MAX_W : TH4_RAW);
   localparam logic signed [VAL_W-1:0] TH7  =
      VAL_W'(TH7_RAW > VAL_MAX_W ? VAL_MAX_W : TH7_RAW);
   localparam logic signed [VAL_W-1:0] TH10 =
      VAL_W'(TH10_RAW > VAL_MAX_W ? VAL_MAX_W : TH10_RAW);
   localparam logic [UOP_W-1:0] LAST_UOP = UOP_W'(NUM_UOPS - 1);
   // ceil(2^17 / 27): exact quotient for every 13-bit partial dividend below 27*256
   localparam logic [12:0] DIV_RECIP = 13'd4855;
   localparam int DIV_SHIFT = 17;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_WA, ST_WA_W, ST_WB, ST_WB_W, ST_RD, ST_AM, ST_AM_W,
      ST_UOP, ST_UOP_W, ST_DIV_SET, ST_DIV, ST_FIN, ST_OUT
   } state_type;

   // corner tensor table
   logic signed [VAL_W-1:0] mem [MEM_DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]       rd_addr;
   logic [ADDR_W-1:0]       wr_addr;
   logic signed [VAL_W-1:0] wr_data;
   logic                    wr_en;

   state_type                  state_ff;
   logic [VTX_W-1:0]           init_vtx_ff;
   logic [COMP_W-1:0]          init_comp_ff;
   logic signed [COORD_W-1:0]  x_ff, y_ff, z_ff;
   logic [VTX_W-1:0]           k_ff;
   logic [COMP_W-1:0]          c_ff;
   word_type                   tmp_ff;
   word_type                   acc_ff;
   word_type                   w_ff [8];
   word_type                   t_ff [9];
   word_type                   p_ff, q_ff, r_ff, p2_ff, q2_ff, p3_ff, pq_ff;
   word_type                   s1_ff, s2_ff, d_ff, n_ff;
   logic                       sat_ff;
   logic [UOP_W-1:0]           uop_idx_ff;
   logic                       div_neg_ff;
   logic [63:0]                div_q_ff;
   logic [4:0]                 div_rem_ff;
   logic [2:0]                 div_cnt_ff;
   logic [AUX_W-1:0]           aux_ff;
   logic                       rsp_valid_ff;
   word_type                   rsp_cubic_ff;
   logic [AUX_W-1:0]           rsp_aux_ff;
   logic                       rsp_sat_ff;

   logic        req_acc;
   logic        rsp_free;
   word_type    x_ext, y_ext, z_ext, fx, fy, fz;
   uop_type     uop_cur;
   word_type    opa, opb, dst_cur, mul_res, acc_sum;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   logic [64:0] comb_res;
   logic [12:0] div_v;
   logic [25:0] div_prod;
   logic [7:0]  div_digit;
   logic [12:0] div_sub;
   logic [4:0]  div_rem_nx;
   word_type    div_res;
   logic        aux_fits;

   function automatic logic signed [VAL_W-1:0] init_val(input logic [VTX_W-1:0] v,
                                                        input logic [COMP_W-1:0] c);
      logic signed [VAL_W-1:0] val;
      case (c) inside
         4'd0, 4'd4: val = TH10;
         4'd8:       val = TH7;
         4'd1, 4'd3: val = NEG_01[v] ? -TH1 : TH1;
         4'd2, 4'd6: val = NEG_02[v] ? -TH4 : TH4;
         4'd5, 4'd7: val = NEG_12[v] ? -TH4 : TH4;
         default:    val = '0;
      endcase
      return val;
   endfunction

   function automatic word_type opnd(input operand_type sel);
      word_type v;
      case (sel)
         OPD_T0:  v = t_ff[0];
         OPD_T1:  v = t_ff[1];
         OPD_T2:  v = t_ff[2];
         OPD_T3:  v = t_ff[3];
         OPD_T4:  v = t_ff[4];
         OPD_T5:  v = t_ff[5];
         OPD_T6:  v = t_ff[6];
         OPD_T7:  v = t_ff[7];
         OPD_T8:  v = t_ff[8];
         OPD_P:   v = p_ff;
         OPD_Q:   v = q_ff;
         OPD_R:   v = r_ff;
         OPD_P2:  v = p2_ff;
         OPD_Q2:  v = q2_ff;
         OPD_P3:  v = p3_ff;
         OPD_PQ:  v = pq_ff;
         OPD_S1:  v = s1_ff;
         OPD_S2:  v = s2_ff;
         OPD_D:   v = d_ff;
         OPD_N:   v = n_ff;
         OPD_ONE: v = ONE_W;
         OPD_K2:  v = K2_W;
         OPD_K4:  v = K4_W;
         OPD_K9:  v = K9_W;
         OPD_K18: v = K18_W;
         OPD_K27: v = K27_W;
         default: v = '0;
      endcase
      return v;
   endfunction

   // handshakes
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && (state_ff == ST_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // corner factors 1 +- coordinate
   always_comb begin
      x_ext = {{(64-COORD_W){x_ff[COORD_W-1]}}, x_ff};
      y_ext = {{(64-COORD_W){y_ff[COORD_W-1]}}, y_ff};
      z_ext = {{(64-COORD_W){z_ff[COORD_W-1]}}, z_ff};
      fx = CORNER_X_POS[k_ff] ? ONE_W + x_ext : ONE_W - x_ext;
      fy = CORNER_Y_POS[k_ff] ? ONE_W + y_ext : ONE_W - y_ext;
      fz = CORNER_Z_POS[k_ff] ? ONE_W + z_ext : ONE_W - z_ext;
   end

   // table port addressing: entry = corner * 9 + component
   always_comb begin
      rd_addr = ADDR_W'({k_ff, 3'b000}) + ADDR_W'(k_ff) + ADDR_W'(c_ff);
      if (state_ff == ST_INIT) begin
         wr_addr = ADDR_W'({init_vtx_ff, 3'b000}) + ADDR_W'(init_vtx_ff)
                   + ADDR_W'(init_comp_ff);
         wr_data = init_val(init_vtx_ff, init_comp_ff);
         wr_en   = 1'b1;
      end else begin
         wr_addr = ADDR_W'({req_ch.vertex, 3'b000}) + ADDR_W'(req_ch.vertex)
                   + ADDR_W'(req_ch.component);
         wr_data = req_ch.value;
         wr_en   = req_acc && (req_ch.op == OP_WRITE) && (req_ch.component <= LAST_COMP);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   // multiplier operand selection
   always_comb begin
      uop_cur      = uop_rom(uop_idx_ff);
      dst_cur      = opnd(uop_cur.dst);
      mul_req.start = (state_ff == ST_WA) || (state_ff == ST_WB) ||
                      (state_ff == ST_AM) || (state_ff == ST_UOP);
      case (state_ff)
         ST_WA: begin
            opa = fx;
            opb = fy;
            mul_req.mode = MUL_FRAC;
         end
         ST_WB: begin
            opa = tmp_ff;
            opb = fz;
            mul_req.mode = MUL_WEIGHT;
         end
         ST_AM: begin
            opa = w_ff[k_ff];
            opb = {{(64-VAL_W){rd_data_ff[VAL_W-1]}}, rd_data_ff};
            mul_req.mode = MUL_RAW;
         end
         default: begin
            opa = opnd(uop_cur.src_a);
            opb = opnd(uop_cur.src_b);
            mul_req.mode = MUL_FRAC;
         end
      endcase
   end

   ttd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .opa     (opa),
      .opb     (opb),
      .res     (mul_res),
      .mul_rsp (mul_rsp)
   );

   // combine product into destination, divider digit, final clamp
   always_comb begin
      acc_sum = acc_ff + mul_res;
      case (uop_cur.acc)
         ACC_ADD: comb_res = sat_arith(dst_cur, mul_res, 1'b0);
         ACC_SUB: comb_res = sat_arith(dst_cur, mul_res, 1'b1);
         default: comb_res = {1'b0, mul_res};
      endcase
      // radix-256 long division: digit from a reciprocal product, remainder carried
      div_v      = {div_rem_ff, div_q_ff[63:56]};
      div_prod   = div_v * DIV_RECIP;
      div_digit  = div_prod[DIV_SHIFT +: 8];
      div_sub    = 13'(div_digit) * 13'(DIV_K);
      div_rem_nx = 5'(div_v - div_sub);
      div_res    = div_neg_ff ? ~div_q_ff : div_q_ff;
      aux_fits   = (&div_res[63:AUX_W-1]) | ~(|div_res[63:AUX_W-1]);
   end

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_vtx_ff  <= '0;
         init_comp_ff <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         c_ff         <= '0;
         uop_idx_ff   <= '0;
         div_cnt_ff   <= '0;
         sat_ff       <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != ST_OUT)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_INIT: begin
               if (init_comp_ff == LAST_COMP) begin
                  init_comp_ff <= '0;
                  init_vtx_ff  <= init_vtx_ff + 3'd1;
                  if (init_vtx_ff == LAST_VTX) state_ff <= ST_IDLE;
               end else begin
                  init_comp_ff <= init_comp_ff + 4'd1;
               end
            end
            ST_IDLE: begin
               if (req_acc && (req_ch.op == OP_EVAL)) begin
                  x_ff     <= req_ch.coord_x;
                  y_ff     <= req_ch.coord_y;
                  z_ff     <= req_ch.coord_z;
                  k_ff     <= '0;
                  c_ff     <= '0;
                  sat_ff   <= 1'b0;
                  state_ff <= ST_WA;
               end
            end
            ST_WA: state_ff <= ST_WA_W;
            ST_WA_W: begin
               if (mul_rsp.done) begin
                  tmp_ff   <= mul_res;
                  state_ff <= ST_WB;
               end
            end
            ST_WB: state_ff <= ST_WB_W;
            ST_WB_W: begin
               if (mul_rsp.done) begin
                  w_ff[k_ff] <= mul_res;
                  k_ff       <= k_ff + 3'd1;
                  if (k_ff == LAST_VTX) begin
                     acc_ff   <= '0;
                     state_ff <= ST_RD;
                  end else begin
                     state_ff <= ST_WA;
                  end
               end
            end
            ST_RD: state_ff <= ST_AM;
            ST_AM: state_ff <= ST_AM_W;
            ST_AM_W: begin
               if (mul_rsp.done) begin
                  k_ff <= k_ff + 3'd1;
                  if (k_ff == LAST_VTX) begin
                     t_ff[c_ff] <= acc_sum >>> FRAC_BITS;
                     acc_ff     <= '0;
                     c_ff       <= c_ff + 4'd1;
                     if (c_ff == LAST_COMP) begin
                        uop_idx_ff <= '0;
                        state_ff   <= ST_UOP;
                     end else begin
                        state_ff <= ST_RD;
                     end
                  end else begin
                     acc_ff   <= acc_sum;
                     state_ff <= ST_RD;
                  end
               end
            end
            ST_UOP: state_ff <= ST_UOP_W;
            ST_UOP_W: begin
               if (mul_rsp.done) begin
                  sat_ff <= sat_ff | mul_rsp.ovf | comb_res[64];
                  case (uop_cur.dst)
                     OPD_P:   p_ff  <= comb_res[63:0];
                     OPD_Q:   q_ff  <= comb_res[63:0];
                     OPD_R:   r_ff  <= comb_res[63:0];
                     OPD_P2:  p2_ff <= comb_res[63:0];
                     OPD_Q2:  q2_ff <= comb_res[63:0];
                     OPD_P3:  p3_ff <= comb_res[63:0];
                     OPD_PQ:  pq_ff <= comb_res[63:0];
                     OPD_S1:  s1_ff <= comb_res[63:0];
                     OPD_S2:  s2_ff <= comb_res[63:0];
                     OPD_D:   d_ff  <= comb_res[63:0];
                     OPD_N:   n_ff  <= comb_res[63:0];
                     default: s1_ff <= comb_res[63:0];
                  endcase
                  uop_idx_ff <= uop_idx_ff + 6'd1;
                  state_ff   <= (uop_idx_ff == LAST_UOP) ? ST_DIV_SET : ST_UOP;
               end
            end
            ST_DIV_SET: begin
               // floor division: work on ~n for negative n, invert the quotient after
               div_neg_ff <= n_ff[63];
               div_q_ff   <= n_ff[63] ? ~n_ff : n_ff;
               div_rem_ff <= '0;
               div_cnt_ff <= '0;
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               div_q_ff   <= {div_q_ff[55:0], div_digit};
               div_rem_ff <= div_rem_nx;
               div_cnt_ff <= div_cnt_ff + 3'd1;
               if (div_cnt_ff == 3'd7) state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (aux_fits)        aux_ff <= div_res[AUX_W-1:0];
               else if (div_res[63]) aux_ff <= AUX_MIN;
               else                 aux_ff <= AUX_MAX;
               sat_ff   <= sat_ff | ~aux_fits;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_cubic_ff <= d_ff;
                  rsp_aux_ff   <= aux_ff;
                  rsp_sat_ff   <= sat_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.disc_cubic = rsp_cubic_ff;
   assign rsp_ch.disc_aux   = rsp_aux_ff;
   assign rsp_ch.saturated  = rsp_sat_ff;

   // checks
   `TTDU_ASSERT_ALWAYS(a_reset_loads_table, clock, reset |=> (state_ff == ST_INIT))
   `TTDU_ASSERT(a_mul_not_immediate, clock, reset, mul_req.start |=> !mul_rsp.done)
   `TTDU_ASSERT(a_eval_clears_flag, clock, reset,
      (req_acc && (req_ch.op == OP_EVAL)) |=> (!sat_ff && (k_ff == '0)))
   `TTDU_ASSERT(a_prog_ends_in_div, clock, reset,
      ((state_ff == ST_UOP_W) && mul_rsp.done && (uop_idx_ff == LAST_UOP))
      |=> (state_ff == ST_DIV_SET))
   `TTDU_ASSERT(a_result_loaded, clock, reset,
      ((state_ff == ST_OUT) && rsp_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))

endmodule

### verif/tb.sv
// Self-checking testbench for the tensor discriminant unit
`timescale 1ns / 1ps

module tb;
   import ttd_pkg::*;

   localparam int FRAC        = 16;
   localparam int DRAIN_WAIT  = 1500;
   localparam int HANG_LIMIT  = 30000;
   localparam int HOLD_CYCLES = 4000;

   typedef struct {
      logic                      op;
      logic [VTX_W-1:0]          vertex;
      logic [COMP_W-1:0]         component;
      logic signed [VAL_W-1:0]   value;
      logic signed [COORD_W-1:0] cx, cy, cz;
      bit                        drain_first;
   } tensor_item_type;

   typedef struct {
      longint           cubic;
      logic [AUX_W-1:0] aux;
      logic             sat;
   } disc_result_type;

   logic clock, reset;
   ttd_req_if req_ch();
   ttd_rsp_if rsp_ch();

   tensor_trilinear_discriminant_unit dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   tensor_item_type pending_q[$];
   disc_result_type disc_q[$];
   longint       corner_tbl[72];
   bit           clamp_seen;
   int           n_errors, n_writes, n_evals, n_results, n_sat, n_taken;
   int           hold_left;
   bit           hold_done;
   int           quiet_cycles;

   // clock and known input levels from time zero
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0; req_ch.op = OP_WRITE; req_ch.vertex = '0;
      req_ch.component = '0; req_ch.value = '0;
      req_ch.coord_x = '0; req_ch.coord_y = '0; req_ch.coord_z = '0;
      rsp_ch.ready = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report(input string what, input longint got, input longint want);
      n_errors++;
      $display("tb: mismatch %s got %0d want %0d (result %0d)", what, got, want, n_results);
   endtask

   // --- fixed-point predictor --------------------------------------------
   function automatic longint clamp64(input logic signed [127:0] v);
      longint hi, lo;
      hi = 64'sh7FFF_FFFF_FFFF_FFFF;
      lo = 64'sh8000_0000_0000_0000;
      if (v > hi) begin clamp_seen = 1'b1; return hi; end
      if (v < lo) begin clamp_seen = 1'b1; return lo; end
      return longint'(v);
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      logic signed [127:0] pa, pb, pr;
      pa = a;
      pb = b;
      pr = (pa * pb) >>> FRAC;
      return clamp64(pr);
   endfunction

   function automatic longint qadd(input longint a, input longint b);
      logic signed [127:0] pa, pb;
      pa = a;
      pb = b;
      return clamp64(pa + pb);
   endfunction

   function automatic longint qsub(input longint a, input longint b);
      logic signed [127:0] pa, pb;
      pa = a;
      pb = b;
      return clamp64(pa - pb);
   endfunction

   function automatic longint qscale(input longint a, input int k);
      return qmul(a, longint'(k) <<< FRAC);
   endfunction

   function automatic longint thirds(input int k);
      longint m;
      m = (longint'(k) * 65536 + 1) / 3;
      return (m > 524287) ? 524287 : m;
   endfunction

   function automatic void load_default_corners();
      longint e01, e02, e12;
      for (int v = 0; v < 8; v++) begin
         e01 = NEG_01[v] ? -thirds(1) : thirds(1);
         e02 = NEG_02[v] ? -thirds(4) : thirds(4);
         e12 = NEG_12[v] ? -thirds(4) : thirds(4);
         corner_tbl[v*9+0] = thirds(10); corner_tbl[v*9+1] = e01; corner_tbl[v*9+2] = e02;
         corner_tbl[v*9+3] = e01; corner_tbl[v*9+4] = thirds(10); corner_tbl[v*9+5] = e12;
         corner_tbl[v*9+6] = e02; corner_tbl[v*9+7] = e12; corner_tbl[v*9+8] = thirds(7);
      end
   endfunction

   function automatic disc_result_type discriminant_at(input longint x, input longint y,
                                                       input longint z);
      disc_result_type r;
      longint one, fx, fy, fz, acc, w[8], t[9];
      longint p, q, rr, s1, p2, q2, p3, pq, d, n, da;
      one = longint'(1) <<< FRAC;
      clamp_seen = 1'b0;
      // corner weights, then weighted sum per component
      for (int k = 0; k < 8; k++) begin
         fx = CORNER_X_POS[k] ? one + x : one - x;
         fy = CORNER_Y_POS[k] ? one + y : one - y;
         fz = CORNER_Z_POS[k] ? one + z : one - z;
         w[k] = (((fx * fy) >>> FRAC) * fz) >>> (FRAC + 3);
      end
      for (int c = 0; c < 9; c++) begin
         acc = 0;
         for (int k = 0; k < 8; k++) acc += w[k] * corner_tbl[k*9+c];
         t[c] = acc >>> FRAC;
      end
      // invariants
      p  = qadd(qadd(t[0], t[4]), t[8]);
      s1 = qsub(qmul(t[4], t[8]), qmul(t[5], t[7]));
      q  = qsub(qmul(t[0], t[4]), qmul(t[1], t[3]));
      q  = qadd(q, s1);
      q  = qadd(q, qsub(qmul(t[8], t[0]), qmul(t[6], t[2])));
      rr = qmul(t[0], s1);
      rr = qsub(rr, qmul(t[1], qsub(qmul(t[3], t[8]), qmul(t[5], t[6]))));
      rr = qadd(rr, qmul(t[2], qsub(qmul(t[3], t[7]), qmul(t[4], t[6]))));
      // discriminant and auxiliary value
      p2 = qmul(p, p);
      q2 = qmul(q, q);
      p3 = qmul(p2, p);
      pq = qmul(p, q);
      d  = qmul(q2, p2);
      d  = qsub(d, qscale(qmul(rr, p3), 4));
      d  = qsub(d, qscale(qmul(q2, q), 4));
      d  = qadd(d, qscale(qmul(pq, rr), 18));
      d  = qsub(d, qscale(qmul(rr, rr), 27));
      n  = qsub(qsub(qscale(pq, 9), qscale(p3, 2)), qscale(rr, 27));
      da = n / 27;
      if (n < 0 && da * 27 != n) da -= 1;
      if (da > 64'sd140737488355327) begin da = 64'sd140737488355327; clamp_seen = 1'b1; end
      if (da < -64'sd140737488355328) begin da = -64'sd140737488355328; clamp_seen = 1'b1; end
      r.cubic = d;
      r.aux   = da[AUX_W-1:0];
      r.sat   = clamp_seen;
      return r;
   endfunction

   function automatic void predict(input tensor_item_type it);
      if (it.op == OP_WRITE) begin
         n_writes++;
         if (it.component <= LAST_COMP)
            corner_tbl[it.vertex*9 + it.component] = longint'(it.value);
      end else begin
         n_evals++;
         disc_q.push_back(discriminant_at(it.cx, it.cy, it.cz));
      end
   endfunction

   // --- stimulus helpers ---------------------------------------------------
   function automatic bit calm_phase();
      return n_taken >= 150 && n_taken < 260;
   endfunction

   function automatic void add_write(input int v, input int c, input int val);
      tensor_item_type it;
      it = '{op: OP_WRITE, vertex: VTX_W'(v), component: COMP_W'(c), value: VAL_W'(val),
             cx: COORD_W'($urandom), cy: COORD_W'($urandom), cz: COORD_W'($urandom),
             drain_first: 1'b0};
      pending_q.push_back(it);
   endfunction

   function automatic void add_eval(input int x, input int y, input int z);
      tensor_item_type it;
      it = '{op: OP_EVAL, vertex: VTX_W'($urandom), component: COMP_W'($urandom),
             value: VAL_W'($urandom), cx: COORD_W'(x), cy: COORD_W'(y), cz: COORD_W'(z),
             drain_first: 1'b0};
      pending_q.push_back(it);
   endfunction

   function automatic int rand_coord();
      int r;
      r = $urandom_range(99);
      if (r < 70) return int'($urandom_range(131072)) - 65536;
      if (r < 85) return ($urandom_range(1) != 0) ? 65536 : -65536;
      return int'($urandom_range(262143)) - 131072;
   endfunction

   function automatic int rand_value();
      int r;
      r = $urandom_range(99);
      if (r < 60) return int'($urandom_range(262144)) - 131072;
      if (r < 75) return ($urandom_range(1) != 0) ? 524287 : -524288;
      return int'($urandom_range(1048575)) - 524288;
   endfunction

   // --- driver --------------------------------------------------------------
   always @(posedge clock) begin
      tensor_item_type it;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            it = '{op: req_ch.op, vertex: req_ch.vertex, component: req_ch.component,
                   value: req_ch.value, cx: req_ch.coord_x, cy: req_ch.coord_y,
                   cz: req_ch.coord_z, drain_first: 1'b0};
            predict(it);
            n_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_q.size() > 0 && !(pending_q[0].drain_first && disc_q.size() > 0)
                && (calm_phase() || $urandom_range(99) >= 36)) begin
               it = pending_q.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.op        <= it.op;
               req_ch.vertex    <= it.vertex;
               req_ch.component <= it.component;
               req_ch.value     <= it.value;
               req_ch.coord_x   <= it.cx;
               req_ch.coord_y   <= it.cy;
               req_ch.coord_z   <= it.cz;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // --- monitor and receiver back-pressure ---------------------------------------
   always @(posedge clock) begin
      disc_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_results++;
            if (disc_q.size() == 0) begin
               report("unexpected item", rsp_ch.disc_cubic, 0);
            end else begin
               want = disc_q.pop_front();
               if (rsp_ch.saturated) n_sat++;
               if (rsp_ch.disc_cubic !== want.cubic)
                  report("disc_cubic", rsp_ch.disc_cubic, want.cubic);
               if (rsp_ch.disc_aux !== want.aux)
                  report("disc_aux", longint'(rsp_ch.disc_aux), longint'($signed(want.aux)));
               if (rsp_ch.saturated !== want.sat)
                  report("saturated", rsp_ch.saturated, want.sat);
            end
         end
         // one long hold-off once traffic is flowing, so the input backs up
         if (!hold_done && n_evals >= 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm_phase() || $urandom_range(99) >= 36;
         end
      end
   end

   // --- watchdog ----------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("tb: timeout with %0d results outstanding", disc_q.size());
         $display("tb: errors");
         $finish;
      end
   end

   // --- sequence --------------------------------------------------------------
   initial begin
      int k;
      tensor_item_type it;
      load_default_corners();

      // default tensors: centre, corners, extremes of the coordinate fields
      add_eval(0, 0, 0);
      add_eval(65536, 65536, 65536);
      add_eval(-65536, -65536, -65536);
      add_eval(65536, -65536, 0);
      add_eval(131071, 131071, 131071);
      add_eval(-131072, -131072, -131072);
      add_eval(-131072, 131071, 32768);
      // component writes: extremes, and indexes above the last that are dropped
      add_write(0, 0, 524287);
      add_write(7, 8, -524288);
      add_write(3, 9, 524287);
      add_write(5, 15, -524288);
      add_write(2, 4, 0);
      add_eval(-65536, -65536, -65536);
      add_eval(65536, 65536, 65536);
      // large first diagonal element at every corner drives products into saturation
      for (int v = 0; v < 8; v++) add_write(v, 0, 524287);
      add_eval(131071, -131072, 131071);
      add_eval(0, 0, 0);

      // random part: mostly small tensors, evaluates mostly inside the cube
      for (int i = 0; i < 480; i++) begin
         if ($urandom_range(99) < 45)
            add_write($urandom_range(7), $urandom_range(15), rand_value());
         else
            add_eval(rand_coord(), rand_coord(), rand_coord());
         if (i == 300) begin
            it = pending_q[pending_q.size()-1];
            it.drain_first = 1'b1;
            pending_q[pending_q.size()-1] = it;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || req_ch.valid || disc_q.size() > 0)
         @(posedge clock);
      k = 0;
      while (k < DRAIN_WAIT) begin
         @(posedge clock);
         k++;
      end
      if (disc_q.size() != 0) report("results left over", disc_q.size(), 0);

      $display("tb: %0d component writes and %0d evaluates sent, %0d results checked",
               n_writes, n_evals, n_results);
      $display("tb: %0d results saturated, one long output stall and one full drain",
               n_sat);
      if (n_errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
